// File: hw/rtl/mdu_pkg.sv
`default_nettype none

package mdu_pkg;

	// Fixed widths of the port fields.
	localparam int unsigned ELEM_W = 12;
	localparam int unsigned RANK_W = 3;
	localparam int unsigned DIST_W = 22;
	localparam int unsigned SUM_W = 64;

	// Defaults and limits.
	localparam int unsigned ELEM_BITS_DEF = 12;
	localparam int unsigned MAX_RANK = 4;
	localparam logic [RANK_W-1:0] RANK_RESET = 3'd2;

	// Depth of the queue of finished sums between the front and the root unit.
	localparam int unsigned QUEUE_DEPTH = 2;

	// One input word: a pair of elements and the end-of-vector mark.
	typedef struct packed {
		logic signed [ELEM_W-1:0] elem_a;
		logic signed [ELEM_W-1:0] elem_b;
		logic                     last_pair;
	} pair_t;

	// One output word.
	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              saturated;
	} dist_t;

	// A finished vector sum waiting for its root.
	typedef struct packed {
		logic [SUM_W-1:0]  power_sum;
		logic              saturated;
		logic [RANK_W-1:0] rank;
	} root_job_t;

endpackage

`default_nettype wire

// File: hw/rtl/mdu_front.sv
`default_nettype none

module mdu_front #(
	parameter int unsigned ELEM_BITS = mdu_pkg::ELEM_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_data,
	input  wire logic              pair_valid,
	output logic                   pair_ready,
	input  wire mdu_pkg::pair_t    pair,
	output logic                   push,
	output mdu_pkg::root_job_t     push_job,
	input  wire logic              q_full
);
	import mdu_pkg::*;

	localparam int unsigned SQ_W = 2 * ELEM_BITS;
	localparam int unsigned CUBE_W = 3 * ELEM_BITS;
	localparam int unsigned TERM_W = 4 * ELEM_BITS;

	logic [RANK_W-1:0]      rank_cfg_q;
	logic [RANK_W-1:0]      eff_rank;
	logic signed [ELEM_BITS:0] a_x;
	logic signed [ELEM_BITS:0] b_x;
	logic signed [ELEM_BITS:0] diff;
	logic [ELEM_BITS:0]     diff_neg;
	logic [ELEM_BITS-1:0]   mag;
	logic                   adv;

	logic                   v_s1;
	logic                   last_s1;
	logic [RANK_W-1:0]      rank_s1;
	logic [ELEM_BITS-1:0]   mag_s1;

	logic                   v_s2;
	logic                   last_s2;
	logic [RANK_W-1:0]      rank_s2;
	logic [ELEM_BITS-1:0]   mag_s2;
	logic [SQ_W-1:0]        sq_s2;

	logic                   v_s3;
	logic                   last_s3;
	logic [RANK_W-1:0]      rank_s3;
	logic [TERM_W-1:0]      term_s3;

	logic [CUBE_W-1:0]      cube;
	logic [TERM_W-1:0]      quad;
	logic [TERM_W-1:0]      term;

	logic [SUM_W-1:0]       sum_q;
	logic                   ovf_q;
	logic [SUM_W:0]         sum_wide;
	logic [SUM_W-1:0]       sum_next;
	logic                   ovf_next;

	// Rank register; zero acts as one and values above the limit act as the limit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_cfg_q <= RANK_RESET;
		end else if (cfg_we) begin
			rank_cfg_q <= cfg_data;
		end
	end

	always_comb begin
		if (rank_cfg_q == '0) begin
			eff_rank = RANK_W'(1);
		end else if (rank_cfg_q > RANK_W'(MAX_RANK)) begin
			eff_rank = RANK_W'(MAX_RANK);
		end else begin
			eff_rank = rank_cfg_q;
		end
	end

	// Sign extend the low element bits and take the magnitude of the difference.
	assign a_x = {pair.elem_a[ELEM_BITS-1], pair.elem_a[ELEM_BITS-1:0]};
	assign b_x = {pair.elem_b[ELEM_BITS-1], pair.elem_b[ELEM_BITS-1:0]};
	assign diff = a_x - b_x;
	assign diff_neg = -diff;
	assign mag = diff[ELEM_BITS] ? diff_neg[ELEM_BITS-1:0] : diff[ELEM_BITS-1:0];

	// The whole front holds only while a finished sum cannot enter the queue.
	assign adv = !(v_s3 && last_s3 && q_full);
	assign pair_ready = adv;

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pair_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Higher powers of the magnitude, one multiplier deep per stage.
	always_comb begin
		cube = sq_s2 * mag_s2;
		quad = sq_s2 * sq_s2;
		case (rank_s2)
			3'd2:    term = TERM_W'(sq_s2);
			3'd3:    term = TERM_W'(cube);
			3'd4:    term = quad;
			default: term = TERM_W'(mag_s2);
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= pair.last_pair;
			rank_s1 <= eff_rank;
			mag_s1  <= mag;
			last_s2 <= last_s1;
			rank_s2 <= rank_s1;
			mag_s2  <= mag_s1;
			sq_s2   <= mag_s1 * mag_s1;
			last_s3 <= last_s2;
			rank_s3 <= rank_s2;
			term_s3 <= term;
		end
	end

	// Saturating accumulation of the powered differences.
	always_comb begin
		sum_wide = {1'b0, sum_q} + {1'b0, SUM_W'(term_s3)};
		if (sum_wide[SUM_W]) begin
			sum_next = '1;
			ovf_next = 1'b1;
		end else begin
			sum_next = sum_wide[SUM_W-1:0];
			ovf_next = ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else if (adv && v_s3) begin
			if (last_s3) begin
				sum_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				sum_q <= sum_next;
				ovf_q <= ovf_next;
			end
		end
	end

	// The last pair of a vector hands the finished sum to the queue.
	assign push = adv && v_s3 && last_s3;
	assign push_job.power_sum = sum_next;
	assign push_job.saturated = ovf_next;
	assign push_job.rank = rank_s3;

endmodule

`default_nettype wire

// File: hw/rtl/mdu_queue.sv
`default_nettype none

module mdu_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire mdu_pkg::root_job_t push_job,
	output logic                    full,
	input  wire logic               pop,
	output mdu_pkg::root_job_t      pop_job,
	output logic                    empty
);
	import mdu_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	root_job_t          entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign pop_job = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/mdu_root.sv
`default_nettype none

module mdu_root (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               job_valid,
	input  wire mdu_pkg::root_job_t job,
	output logic                    pop,
	output logic                    dist_valid,
	input  wire logic               dist_ready,
	output mdu_pkg::dist_t          result
);
	import mdu_pkg::*;

	localparam int unsigned HALF_W = SUM_W / 2;
	localparam int unsigned PROD_W = HALF_W + DIST_W;
	localparam int unsigned BIT_W = $clog2(DIST_W);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_CMP  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]         state_q;
	logic [SUM_W-1:0]   sum_q;
	logic               sat_q;
	logic [RANK_W-1:0]  rank_q;
	logic [DIST_W-1:0]  root_q;
	logic [DIST_W-1:0]  cand_q;
	logic [BIT_W-1:0]   bit_q;
	logic [SUM_W-1:0]   acc_q;
	logic               ovf_q;
	logic [1:0]         cnt_q;
	logic [PROD_W-1:0]  plo_q;
	logic [PROD_W-1:0]  phi_q;
	dist_t              dist_q;
	logic               dist_valid_q;

	logic [DIST_W-1:0]  cand;
	logic [SUM_W:0]     add_w;
	logic               ovf_mul;
	logic               out_free;

	assign pop = (state_q == ST_IDLE) && job_valid;
	assign out_free = !dist_valid_q || dist_ready;

	// Next candidate: the current root with the bit under test set.
	assign cand = root_q | (DIST_W'(1) << bit_q);

	// Recombine the two partial products; any bit at or above 2^64 fails the test.
	always_comb begin
		add_w = {{(SUM_W + 1 - PROD_W){1'b0}}, plo_q}
			+ {1'b0, phi_q[HALF_W-1:0], {HALF_W{1'b0}}};
		ovf_mul = ovf_q || (|phi_q[PROD_W-1:HALF_W]) || add_w[SUM_W];
	end

	// Bit-by-bit root search: each candidate is raised to the rank by repeated
	// multiplication and kept when its power does not pass the sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= (rank_q == RANK_W'(1)) ? ST_CMP : ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= (ovf_mul || cnt_q == 2'd1) ? ST_CMP : ST_MUL;
				end
				ST_CMP: begin
					state_q <= (bit_q == '0) ? ST_OUT : ST_LOAD;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath of the search.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sum_q  <= job.power_sum;
				sat_q  <= job.saturated;
				rank_q <= job.rank;
				root_q <= '0;
				bit_q  <= BIT_W'(DIST_W - 1);
			end
			ST_LOAD: begin
				cand_q <= cand;
				acc_q  <= SUM_W'(cand);
				ovf_q  <= 1'b0;
				cnt_q  <= 2'(rank_q - RANK_W'(1));
			end
			ST_MUL: begin
				plo_q <= acc_q[HALF_W-1:0] * cand_q;
				phi_q <= acc_q[SUM_W-1:HALF_W] * cand_q;
			end
			ST_ADD: begin
				acc_q <= add_w[SUM_W-1:0];
				ovf_q <= ovf_mul;
				cnt_q <= cnt_q - 2'd1;
			end
			ST_CMP: begin
				if (!ovf_q && acc_q <= sum_q) begin
					root_q <= cand_q;
				end
				if (bit_q != '0) begin
					bit_q <= bit_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register; the search of the next vector may run while it waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			dist_valid_q <= 1'b1;
		end else if (dist_ready) begin
			dist_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			dist_q.distance  <= root_q;
			dist_q.saturated <= sat_q;
		end
	end

	assign dist_valid = dist_valid_q;
	assign result = dist_q;

endmodule

`default_nettype wire

// File: hw/rtl/minkowski_distance_unit.sv
`default_nettype none

// Streaming Minkowski distance. Each pair word carries one element of each
// vector; the block adds |elem_a - elem_b| raised to the rank p (the rank
// register, 0 read as 1, above 4 read as 4) into an exact 64-bit sum that
// saturates at 2^64-1 and then flags the result. The word with last_pair set
// closes the vector: one result word follows with the floor of the p-th root
// of the sum (clamped to 22 bits) and the sum starts again from zero. The front
// accepts one pair per clock while it is not held, and hands each finished sum
// through its registers s1, s2 and s3 to a two-entry queue. The root unit works
// one vector at a time: after it takes the sum, for each of the 22 root bits it
// loads the candidate, runs each of the p-1 multiplies through its 32x22
// multiplier pair as a multiply step and an add step, and then compares; last
// it hands over the result. A candidate whose power overflows early ends its
// multiplies sooner, and a result that waits on the receiver holds the root
// unit longer. Vectors that arrive faster than the root unit finishes them
// fill the queue; once it is full, a closing pair at the end of the front
// holds the input until the root unit takes a sum. Write the rank register
// only while the block is idle.
module minkowski_distance_unit #(
	parameter int unsigned ELEM_BITS = mdu_pkg::ELEM_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [2:0]      cfg_data,
	input  wire logic            pair_valid,
	output logic                 pair_ready,
	input  wire mdu_pkg::pair_t  pair,
	output logic                 dist_valid,
	input  wire logic            dist_ready,
	output mdu_pkg::dist_t       result
);
	import mdu_pkg::*;

	logic      push;
	root_job_t push_job;
	logic      q_full;
	logic      pop;
	root_job_t pop_job;
	logic      q_empty;

	// Front: element difference, powers and the running sum.
	mdu_front #(
		.ELEM_BITS(ELEM_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.pair_valid (pair_valid),
		.pair_ready (pair_ready),
		.pair       (pair),
		.push       (push),
		.push_job   (push_job),
		.q_full     (q_full)
	);

	// Queue of finished sums.
	mdu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	// Back: root search and output register.
	mdu_root u_root (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (!q_empty),
		.job        (pop_job),
		.pop        (pop),
		.dist_valid (dist_valid),
		.dist_ready (dist_ready),
		.result     (result)
	);

	// A finished sum never meets a full queue.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("finished sum pushed into a full queue");

	// The root unit never takes from an empty queue.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("root unit popped an empty queue");

	// The input stalls only because the queue is full.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pair_ready |-> q_full)
		else $error("input stalled while the queue had room");

endmodule

`default_nettype wire

// File: bench/distance_checker.sv
`default_nettype none

module distance_checker (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [2:0]      cfg_data,
	input  wire logic            pair_valid,
	input  wire logic            pair_ready,
	input  wire mdu_pkg::pair_t  pair,
	input  wire logic            dist_valid,
	input  wire logic            dist_ready,
	input  wire mdu_pkg::dist_t  result,
	output int                   fail_count,
	output int                   pending
);

	import mdu_pkg::*;

	// Shadow copy of the rank register and of the running vector sum.
	logic [RANK_W-1:0] rank_reg;
	logic [SUM_W-1:0]  power_sum;
	logic              overflow_seen;
	dist_t             expected_dist[$];
	dist_t             want;

	// Rank 0 acts as 1 and anything above the top rank acts as the top rank.
	function automatic int unsigned used_rank(input logic [RANK_W-1:0] r);
		if (r == '0)
			return 1;
		if (r > MAX_RANK)
			return MAX_RANK;
		return 32'(r);
	endfunction

	// Exact power; a 22-bit base to the fourth still fits in 128 bits.
	function automatic logic [127:0] raise(input logic [SUM_W-1:0] base, input int unsigned p);
		logic [127:0] acc;
		acc = 128'd1;
		for (int i = 0; i < p; i++)
			acc = acc * base;
		return acc;
	endfunction

	// Largest r of DIST_W bits with r^p <= s, found one bit at a time.
	function automatic logic [DIST_W-1:0] floor_root(input logic [SUM_W-1:0] s,
		input int unsigned p);
		logic [DIST_W-1:0] r;
		logic [DIST_W-1:0] c;
		r = '0;
		for (int b = DIST_W - 1; b >= 0; b--) begin
			c = r;
			c[b] = 1'b1;
			if (raise(SUM_W'(c), p) <= {64'd0, s})
				r = c;
		end
		return r;
	endfunction

	// Add one powered difference; a closing word queues the expected distance.
	task automatic take_pair(input pair_t w);
		logic [ELEM_W:0]   diff;
		logic [ELEM_W:0]   magn;
		logic [SUM_W-1:0]  term;
		int unsigned       p;
		dist_t             res;
		diff = {w.elem_a[ELEM_W-1], w.elem_a} - {w.elem_b[ELEM_W-1], w.elem_b};
		magn = diff[ELEM_W] ? (~diff + 1'b1) : diff;
		p = used_rank(rank_reg);
		term = SUM_W'(raise({{(SUM_W-ELEM_W-1){1'b0}}, magn}, p));
		if (term > ({SUM_W{1'b1}} - power_sum)) begin
			power_sum = {SUM_W{1'b1}};
			overflow_seen = 1'b1;
		end else begin
			power_sum = power_sum + term;
		end
		if (w.last_pair) begin
			res.distance = floor_root(power_sum, p);
			res.saturated = overflow_seen;
			expected_dist.push_back(res);
			power_sum = '0;
			overflow_seen = 1'b0;
		end
	endtask

	// Results are checked before new pairs are taken; a pair never yields a
	// word in its own cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_reg = RANK_RESET;
			power_sum = '0;
			overflow_seen = 1'b0;
			expected_dist.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (dist_valid && dist_ready) begin
				if (expected_dist.size() == 0) begin
					$display("%0t: result word with none expected, got distance %0d saturated %0b",
						$time, result.distance, result.saturated);
					fail_count++;
				end else begin
					want = expected_dist.pop_front();
					if (result.distance !== want.distance) begin
						$display("%0t: distance mismatch, expected %0d, got %0d",
							$time, want.distance, result.distance);
						fail_count++;
					end
					if (result.saturated !== want.saturated) begin
						$display("%0t: saturated mismatch, expected %0b, got %0b",
							$time, want.saturated, result.saturated);
						fail_count++;
					end
				end
			end
			if (cfg_we)
				rank_reg = cfg_data;
			if (pair_valid && pair_ready)
				take_pair(pair);
			pending = expected_dist.size();
		end
	end

endmodule

`default_nettype wire

// File: bench/tb.sv
`default_nettype none

module tb;

	import mdu_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 400;
	localparam int HOLD_CYCLES  = 1000;
	localparam int PHASE_ITEMS  = 90;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_data = 3'd0;
	logic        pair_valid = 1'b0;
	logic        pair_ready;
	pair_t       pair_word = '0;
	logic        dist_valid;
	logic        dist_ready = 1'b0;
	dist_t       dist_word;
	int          fail_count;
	int          pending;

	// Idle percentages of sender and receiver, and long hold requests for the receiver.
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_requests = 0;

	minkowski_distance_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.pair_valid (pair_valid),
		.pair_ready (pair_ready),
		.pair       (pair_word),
		.dist_valid (dist_valid),
		.dist_ready (dist_ready),
		.result     (dist_word)
	);

	distance_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.pair_valid (pair_valid),
		.pair_ready (pair_ready),
		.pair       (pair_word),
		.dist_valid (dist_valid),
		.dist_ready (dist_ready),
		.result     (dist_word),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog on the total cycle count.
	initial begin : watchdog
		int n;
		n = 0;
		while (n < CYCLE_LIMIT) begin
			@(posedge clk);
			n++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	initial begin : receiver
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				dist_ready <= 1'b0;
			end else begin
				dist_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic set_idling(input idle_mode_t mode);
		send_idle_pct = (mode == IDLE_SEND) ? 74 : (mode == IDLE_BOTH) ? 26 : 0;
		recv_stall_pct = (mode == IDLE_RECV) ? 74 : (mode == IDLE_BOTH) ? 26 : 0;
	endtask

	// Offer one word; returns at the falling edge after it was accepted.
	task automatic send_pair(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
		input logic last);
		pair_t w;
		w.elem_a = a;
		w.elem_b = b;
		w.last_pair = last;
		while ($urandom_range(99) < send_idle_pct) begin
			pair_valid <= 1'b0;
			@(negedge clk);
		end
		pair_valid <= 1'b1;
		pair_word <= w;
		do
			@(posedge clk);
		while (!pair_ready);
		@(negedge clk);
	endtask

	// Wait until every distance has come back and the root unit has settled.
	task automatic drain;
		pair_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_rank(input logic [2:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Extremes and zero show up often; the rest is uniform.
	function automatic logic [ELEM_W-1:0] pick_elem();
		case ($urandom_range(7))
			0: return 12'h800;
			1: return 12'h7FF;
			2: return 12'h000;
			default: return ELEM_W'($urandom());
		endcase
	endfunction

	// Mostly short vectors, some medium ones, a few long ones.
	function automatic int pick_length();
		int roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return $urandom_range(8, 1);
		if (roll < 95)
			return $urandom_range(40, 9);
		return $urandom_range(200, 41);
	endfunction

	task automatic random_vectors(input int target);
		int count;
		int len;
		logic [ELEM_W-1:0] a;
		logic [ELEM_W-1:0] b;
		count = 0;
		while (count < target) begin
			len = pick_length();
			for (int i = 0; i < len; i++) begin
				a = pick_elem();
				b = ($urandom_range(9) == 0) ? a : pick_elem();
				send_pair(a, b, i == len - 1);
				count++;
			end
		end
	endtask

	// A vector of len words all at the widest difference.
	task automatic wide_vector(input int len);
		for (int i = 0; i < len; i++) begin
			if (i[0])
				send_pair(12'h800, 12'h7FF, i == len - 1);
			else
				send_pair(12'h7FF, 12'h800, i == len - 1);
		end
	endtask

	initial begin : stimulus
		logic [2:0] ranks [8];
		ranks = '{3'd1, 3'd3, 3'd4, 3'd0, 3'd5, 3'd2, 3'd7, 3'd6};
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words at the reset rank with no idling.
		set_idling(IDLE_NONE);
		send_pair(12'h7FF, 12'h800, 1'b1);
		send_pair(12'h800, 12'h7FF, 1'b1);
		send_pair(12'h000, 12'h000, 1'b1);
		send_pair(12'h800, 12'h800, 1'b1);
		send_pair(12'h7FF, 12'h7FF, 1'b1);
		send_pair(12'd3, 12'd0, 1'b0);
		send_pair(12'd0, 12'd4, 1'b1);
		send_pair(12'd1, 12'd2, 1'b0);
		send_pair(-12'sd5, -12'sd5, 1'b0);
		send_pair(12'd100, -12'sd100, 1'b1);
		send_pair(-12'sd1, 12'd0, 1'b1);
		send_pair(12'h7FF, 12'h800, 1'b0);
		send_pair(12'h800, 12'h7FF, 1'b1);

		// Random phases across every rank setting and every idling pattern.
		foreach (ranks[i]) begin
			write_rank(ranks[i]);
			set_idling(idle_mode_t'(i % 4));
			if (i == 4)
				hold_requests++;
			random_vectors(PHASE_ITEMS);
		end

		// Linear rank: a sum whose root is too wide for the port, then a short vector.
		write_rank(3'd1);
		set_idling(IDLE_NONE);
		wide_vector(1030);
		send_pair(12'd7, 12'd2, 1'b1);

		drain();
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
